FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers: concurrent checks clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BTF_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BTF_ASSERT(lbl, clk, rstn, ante, cons)
`define BTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hdl/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg
// Shared constants and types of the box tiling fold unit.
// ----------------------------------------------------------------------------
package btf_pkg;

  localparam int WordBitsDef = 21;
  localparam int FracBitsDef = 10;
  localparam int NumRegs     = 8;
  localparam int RegIdxBits  = 3;
  localparam int ModeBits    = 19;
  localparam int ModeCupdBit = 18;
  localparam int AxisModeBits = 6;

  typedef enum logic [RegIdxBits-1:0] {
    REG_SIZE = 3'd0,
    REG_PRE  = 3'd1,
    REG_TOFF = 3'd2,
    REG_WPOS = 3'd3,
    REG_WNEG = 3'd4,
    REG_CHI  = 3'd5,
    REG_CLO  = 3'd6,
    REG_MODE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic ord;
    logic clamp;
    logic negate;
    logic absv;
    logic win;
    logic en;
  } axis_mode_t;

endpackage

FILE: hdl/btf_axis.sv
// ----------------------------------------------------------------------------
// btf_axis
// One axis of the fold: pre-offset, window test, abs and tile offset,
// pipelined remainder by the tile size, negate, clamp, saturate.
// ----------------------------------------------------------------------------
module btf_axis import btf_pkg::*; #(
  parameter int WordBits = WordBitsDef,
  parameter int FracBits = FracBitsDef
) (
  input  logic                       clk_i,
  input  logic signed [WordBits-1:0] point_i,
  input  logic signed [WordBits-1:0] const_i,
  input  logic signed [WordBits-1:0] pre_i,
  input  logic signed [WordBits-1:0] size_i,
  input  logic signed [WordBits-1:0] toff_i,
  input  logic signed [WordBits-1:0] wpos_i,
  input  logic signed [WordBits-1:0] wneg_i,
  input  logic signed [WordBits-1:0] chi_i,
  input  logic signed [WordBits-1:0] clo_i,
  input  axis_mode_t                 mode_i,
  output logic signed [WordBits-1:0] folded_o,
  output logic signed [WordBits-1:0] const_o
);

  localparam int W  = WordBits;
  localparam int VW = W + 1;
  localparam int AW = W + 2;
  localparam int TW = W + 3;
  localparam int NB = W + 2;
  localparam int MW = 2 * W + 1;
  localparam int PW = 2 * W + FracBits + 3;
  localparam int XW = W + 5;
  localparam logic signed [W:0] Half = $signed((W+1)'(2 ** (FracBits - 1)));
  localparam logic signed [W:0] SatMax = $signed((W+1)'(2 ** (W - 1) - 1));

  typedef struct packed {
    logic                 act;
    logic                 neg;
    logic signed [TW-1:0] t;
    logic signed [VW-1:0] v;
    logic signed [W-1:0]  c;
  } carry_t;

  logic signed [VW-1:0] v1_q;
  logic signed [W-1:0]  c1_q;
  logic signed [MW-1:0] up2_q, dn2_q;
  logic signed [TW-1:0] t2_q;
  logic signed [VW-1:0] v2_q;
  logic signed [W-1:0]  c2_q;
  logic signed [W:0]    wpos_h, wneg_h;
  logic signed [AW-1:0] va;
  logic signed [PW-1:0] lhs;
  logic                 act3;
  logic signed [TW-1:0] t_abs;
  logic [W-1:0]         ms;
  logic [W-1:0]         rem_q [NB+1];
  logic [NB-1:0]        dvd_q [NB+1];
  carry_t               car_q [NB+1];
  logic signed [XW-1:0] mres, w_d, w_q, x, a, hi, lo, u_q;
  logic signed [W-1:0]  c5_q, c6_q;
  logic                 en5_q;

  assign ms = size_i[W-1] ? W'(-size_i) : size_i;

  always_ff @(posedge clk_i) begin
    v1_q <= VW'(point_i) - VW'(pre_i);
    c1_q <= const_i;
  end

  assign wpos_h = (W+1)'(wpos_i) + Half;
  assign wneg_h = (W+1)'(wneg_i) + Half;
  assign va = (mode_i.absv && v1_q < 0) ? -AW'(v1_q) : AW'(v1_q);

  always_ff @(posedge clk_i) begin
    up2_q <= MW'(wpos_h) * MW'(size_i);
    dn2_q <= MW'(wneg_h) * MW'(size_i);
    t2_q  <= TW'(va) - TW'(toff_i);
    v2_q  <= v1_q;
    c2_q  <= c1_q;
  end

  assign lhs   = PW'(v2_q) <<< FracBits;
  assign act3  = !mode_i.win || ((lhs < PW'(up2_q)) && (lhs + PW'(dn2_q) > 0));
  assign t_abs = (t2_q < 0) ? -t2_q : t2_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]     <= '0;
    dvd_q[0]     <= t_abs[NB-1:0];
    car_q[0].act <= act3;
    car_q[0].neg <= t2_q < 0;
    car_q[0].t   <= t2_q;
    car_q[0].v   <= v2_q;
    car_q[0].c   <= c2_q;
  end

  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [W:0] trial;
    assign trial = {rem_q[k], dvd_q[k][NB-1]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= (trial >= {1'b0, ms}) ? W'(trial - {1'b0, ms}) : W'(trial);
      dvd_q[k+1] <= dvd_q[k] << 1;
      car_q[k+1] <= car_q[k];
    end
  end

  always_comb begin
    if ({rem_q[NB], 1'b0} >= {1'b0, ms}) begin
      mres = $signed(XW'(rem_q[NB])) - $signed(XW'(ms));
    end else begin
      mres = $signed(XW'(rem_q[NB]));
    end
    if (!mode_i.en || !car_q[NB].act) begin
      w_d = XW'(car_q[NB].v);
    end else if (ms == '0) begin
      w_d = XW'(car_q[NB].t);
    end else begin
      w_d = car_q[NB].neg ? -mres : mres;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    c5_q  <= car_q[NB].c;
    en5_q <= mode_i.en;
  end

  assign hi = XW'(c5_q) + XW'(chi_i);
  assign lo = XW'(c5_q) - XW'(clo_i);

  always_comb begin
    x = (en5_q && mode_i.negate) ? -w_q : w_q;
    a = x;
    if (en5_q && mode_i.clamp) begin
      if (!mode_i.ord) begin
        a = -x;
        if (hi < a) a = hi;
        if (lo > a) a = lo;
      end else begin
        if (lo > a) a = lo;
        a = -a;
        if (hi < a) a = hi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q  <= a;
    c6_q <= c5_q;
  end

  always_comb begin
    if (u_q > XW'(SatMax)) begin
      folded_o = W'(SatMax);
    end else if (u_q < -XW'(SatMax) - 1) begin
      folded_o = W'(-XW'(SatMax) - 1);
    end else begin
      folded_o = W'(u_q);
    end
  end

  assign const_o = c6_q;

endmodule

FILE: hdl/box_tiling_fold_3d_unit.sv
// ----------------------------------------------------------------------------
// box_tiling_fold_3d_unit
// Domain-repetition fold of a 3D point with a constant point, Q10.10.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start with point_* and const_*; busy is always low, so
//   a request is taken on every cycle that start is high.
//   Each request gives one result on folded_*_o and next_const_*_o, marked
//   by done_o for a single cycle; the receiver must take it then.
//   Throughput is one request per cycle. The depth is set by the remainder
//   pipeline, one dividend bit per stage over WordBits + 2 bits, plus the
//   offset, window multiply, window compare, rounding, clamp and output stages.
//   Configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i; the user must write them only while no request is in
//   flight, as the unit does not enforce it. Writes take effect at once.
//   Reset clears in-flight valid bits and loads the register defaults
//   (tile size 2.0, window 1.0, x axis enabled).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_tiling_fold_3d_unit import btf_pkg::*; #(
  parameter int WordBits = WordBitsDef,
  parameter int FracBits = FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  output logic                         done_o,
  input  logic                         cfg_we_i,
  input  logic [RegIdxBits-1:0]        cfg_idx_i,
  input  logic [3*WordBits-1:0]        cfg_wdata_i,
  input  logic signed [WordBits-1:0]   point_x_i,
  input  logic signed [WordBits-1:0]   point_y_i,
  input  logic signed [WordBits-1:0]   point_z_i,
  input  logic signed [WordBits-1:0]   const_x_i,
  input  logic signed [WordBits-1:0]   const_y_i,
  input  logic signed [WordBits-1:0]   const_z_i,
  output logic signed [WordBits-1:0]   folded_x_o,
  output logic signed [WordBits-1:0]   folded_y_o,
  output logic signed [WordBits-1:0]   folded_z_o,
  output logic signed [WordBits-1:0]   next_const_x_o,
  output logic signed [WordBits-1:0]   next_const_y_o,
  output logic signed [WordBits-1:0]   next_const_z_o
);

  localparam int W    = WordBits;
  localparam int CfgW = 3 * WordBits;
  localparam int Lat  = WordBits + 8;

  logic [CfgW-1:0]     size_q, pre_q, toff_q, wpos_q, wneg_q, chi_q, clo_q;
  logic [ModeBits-1:0] mode_q;
  logic [Lat-1:0]      vld_q;
  logic signed [W-1:0] pts [3];
  logic signed [W-1:0] cst [3];
  logic signed [W-1:0] fold [3];
  logic signed [W-1:0] cout [3];
  logic signed [W-1:0] fold_q [3];
  logic signed [W-1:0] ncst_q [3];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= {3{W'(2 ** (FracBits + 1))}};
      pre_q  <= '0;
      toff_q <= '0;
      wpos_q <= {3{W'(2 ** FracBits)}};
      wneg_q <= {3{W'(2 ** FracBits)}};
      chi_q  <= '0;
      clo_q  <= '0;
      mode_q <= ModeBits'(1);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SIZE: size_q <= cfg_wdata_i;
        REG_PRE:  pre_q  <= cfg_wdata_i;
        REG_TOFF: toff_q <= cfg_wdata_i;
        REG_WPOS: wpos_q <= cfg_wdata_i;
        REG_WNEG: wneg_q <= cfg_wdata_i;
        REG_CHI:  chi_q  <= cfg_wdata_i;
        REG_CLO:  clo_q  <= cfg_wdata_i;
        REG_MODE: mode_q <= cfg_wdata_i[ModeBits-1:0];
        default:  mode_q <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start & ~busy};
    end
  end

  assign pts[0] = point_x_i;
  assign pts[1] = point_y_i;
  assign pts[2] = point_z_i;
  assign cst[0] = const_x_i;
  assign cst[1] = const_y_i;
  assign cst[2] = const_z_i;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    btf_axis #(
      .WordBits(WordBits),
      .FracBits(FracBits)
    ) u_axis (
      .clk_i   (clk_i),
      .point_i (pts[k]),
      .const_i (cst[k]),
      .pre_i   ($signed(pre_q[k*W +: W])),
      .size_i  ($signed(size_q[k*W +: W])),
      .toff_i  ($signed(toff_q[k*W +: W])),
      .wpos_i  ($signed(wpos_q[k*W +: W])),
      .wneg_i  ($signed(wneg_q[k*W +: W])),
      .chi_i   ($signed(chi_q[k*W +: W])),
      .clo_i   ($signed(clo_q[k*W +: W])),
      .mode_i  (axis_mode_t'(mode_q[k*AxisModeBits +: AxisModeBits])),
      .folded_o(fold[k]),
      .const_o (cout[k])
    );

    always_ff @(posedge clk_i) begin
      fold_q[k] <= fold[k];
      ncst_q[k] <= mode_q[ModeCupdBit] ? fold[k] : cout[k];
    end
  end

  assign done_o         = vld_q[Lat-1];
  assign folded_x_o     = fold_q[0];
  assign folded_y_o     = fold_q[1];
  assign folded_z_o     = fold_q[2];
  assign next_const_x_o = ncst_q[0];
  assign next_const_y_o = ncst_q[1];
  assign next_const_z_o = ncst_q[2];

  `BTF_ASSERT(a_latency, clk_i, rst_ni, start && !busy, ##Lat done_o)
  `BTF_ASSERT(a_cupd, clk_i, rst_ni, done_o && mode_q[ModeCupdBit], next_const_y_o == folded_y_o)
  `BTF_ASSERT(a_cpass, clk_i, rst_ni, done_o && !mode_q[ModeCupdBit], next_const_x_o == $past(const_x_i, Lat))

endmodule
